>>> src/bir_pkg.sv
// Shared types and constants for the beacon interval regularity unit.
// Holds field widths, status codes, controller states and the command/status structs.
// No dependencies.
package bir_pkg;

    localparam int unsigned MAX_INTERVALS = 256;

    localparam int IV_W       = 24;
    localparam int CNT_W      = 9;
    localparam int SUM_W      = 32;
    localparam int SQS_W      = 56;
    localparam int CV_W       = 10;
    localparam int LIM2_W     = 2 * CV_W;
    localparam int S2_W       = 2 * SUM_W;
    localparam int SCALE_W    = 14;
    localparam int LHS_W      = S2_W + SCALE_W;
    localparam int RHS_PART_W = SUM_W + LIM2_W;
    localparam int RHS_W      = S2_W + LIM2_W;
    localparam int STAT_W     = 3;
    localparam int OUT_W      = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVALS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CV_PERCENT = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] MIN_INTERVALS_RST  = CNT_W'(8);
    localparam logic [CV_W-1:0]  MAX_CV_PERCENT_RST = CV_W'(30);

    // percent scale squared: (100 * stddev / mean)^2 test
    localparam logic [SCALE_W-1:0] CV_SCALE_SQ = SCALE_W'(10000);

    typedef enum logic [STAT_W-1:0] {
        STAT_REGULAR    = 3'd0,
        STAT_TOO_FEW    = 3'd1,
        STAT_MEAN_SMALL = 3'd2,
        STAT_IRREGULAR  = 3'd3,
        STAT_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCUM,
        S_PRODUCT,
        S_NQ,
        S_DIFF,
        S_LHS,
        S_RHS_LO,
        S_RHS_HI,
        S_COMPARE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load_item;
        logic accumulate;
        logic calc_product;
        logic calc_nq;
        logic calc_diff;
        logic calc_lhs;
        logic calc_rhs_lo;
        logic calc_rhs_hi;
        logic calc_compare;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic item_last;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> src/beacon_interval_regularity_unit.sv
// Beacon interval regularity unit: CV test over a set of connection intervals.
// Each interval is captured with its square, then accumulated; a set-ending interval then
// runs the chain of registered multiply, subtract and compare steps, and its result is
// loaded into the output register after them. A waiting result stalls only the next set end.
// Reset (aresetn low, synchronous) clears the accumulators, the output valid and the
// registers to min_intervals 8, max_cv_percent 30.
module beacon_interval_regularity_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bir_pkg::IV_W-1:0]          s_tdata,   // [23:0] interval_ms
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bir_pkg::OUT_W-1:0]         m_tdata,   // [0] is_beacon, [3:1] status, [7:4] 0
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bir_pkg::*;

    logic [CNT_W-1:0] min_intervals_reg;
    logic [CV_W-1:0]  max_cv_percent_reg;
    dp_cmd_t          dp_cmd;
    dp_stat_t         dp_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_intervals_reg  <= MIN_INTERVALS_RST;
            max_cv_percent_reg <= MAX_CV_PERCENT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MIN_INTERVALS) begin
                min_intervals_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_index == REG_MAX_CV_PERCENT) begin
                max_cv_percent_reg <= cfg_data[CV_W-1:0];
            end
        end
    end

    bir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    bir_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .dp_cmd         (dp_cmd),
        .dp_stat        (dp_stat),
        .interval_ms    (s_tdata),
        .item_last      (s_tlast),
        .min_intervals  (min_intervals_reg),
        .max_cv_percent (max_cv_percent_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata)
    );

    assign s_tready = dp_cmd.in_ready;

    // a mid-set transaction never produces a result on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
        else $error("result raised right after a mid-set interval");

    // never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.load_result |-> !(m_tvalid && !m_tready))
        else $error("pending result overwritten");

    // is_beacon agrees with status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == STAT_REGULAR)))
        else $error("is_beacon inconsistent with status");

endmodule

>>> src/bir_ctrl.sv
// Controller state machine for the beacon interval regularity unit.
// Sequences item accumulation and the multi-step variance test; depends on bir_pkg.
module bir_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  bir_pkg::dp_stat_t dp_stat,
    output bir_pkg::dp_cmd_t  dp_cmd
);
    import bir_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM: begin
                state_next = dp_stat.item_last ? S_PRODUCT : S_IDLE;
            end
            S_PRODUCT: state_next = S_NQ;
            S_NQ:      state_next = S_DIFF;
            S_DIFF:    state_next = S_LHS;
            S_LHS:     state_next = S_RHS_LO;
            S_RHS_LO:  state_next = S_RHS_HI;
            S_RHS_HI:  state_next = S_COMPARE;
            S_COMPARE: state_next = S_RESULT;
            S_RESULT: begin
                // hold until the output register is free
                if (!dp_stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd              = '0;
        dp_cmd.in_ready     = (state_reg == S_IDLE);
        dp_cmd.load_item    = (state_reg == S_IDLE) && s_tvalid;
        dp_cmd.accumulate   = (state_reg == S_ACCUM);
        dp_cmd.calc_product = (state_reg == S_PRODUCT);
        dp_cmd.calc_nq      = (state_reg == S_NQ);
        dp_cmd.calc_diff    = (state_reg == S_DIFF);
        dp_cmd.calc_lhs     = (state_reg == S_LHS);
        dp_cmd.calc_rhs_lo  = (state_reg == S_RHS_LO);
        dp_cmd.calc_rhs_hi  = (state_reg == S_RHS_HI);
        dp_cmd.calc_compare = (state_reg == S_COMPARE);
        dp_cmd.load_result  = (state_reg == S_RESULT) && !dp_stat.out_busy;
    end

endmodule

>>> src/bir_datapath.sv
// Datapath for the beacon interval regularity unit: accumulators, the
// registered multiply/compare steps and the output register; depends on bir_pkg.
module bir_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bir_pkg::dp_cmd_t              dp_cmd,
    output bir_pkg::dp_stat_t             dp_stat,
    input  logic [bir_pkg::IV_W-1:0]      interval_ms,
    input  logic                          item_last,
    input  logic [bir_pkg::CNT_W-1:0]     min_intervals,
    input  logic [bir_pkg::CV_W-1:0]      max_cv_percent,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [bir_pkg::OUT_W-1:0]     m_tdata
);
    import bir_pkg::*;

    logic [IV_W-1:0]       iv_reg;
    logic [2*IV_W-1:0]     iv_sq_reg;
    logic                  last_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SQS_W-1:0]      sqsum_reg;
    logic                  overflow_reg;

    logic [S2_W-1:0]       s2_reg;
    logic [LIM2_W-1:0]     lim2_reg;
    logic [S2_W-1:0]       nq_reg;
    logic [S2_W-1:0]       diff_reg;
    logic [LHS_W-1:0]      lhs_reg;
    logic [RHS_PART_W-1:0] rhs_lo_reg;
    logic [RHS_PART_W-1:0] rhs_hi_reg;
    status_t               verdict_reg;

    logic                  m_tvalid_reg;
    status_t               m_status_reg;

    logic [CNT_W+SQS_W-1:0] nq_full;
    logic [RHS_W-1:0]       rhs_full;
    logic                   cv_below;
    status_t                verdict_next;

    assign nq_full  = count_reg * sqsum_reg;
    assign rhs_full = {rhs_hi_reg, {SUM_W{1'b0}}} + {{SUM_W{1'b0}}, rhs_lo_reg};
    assign cv_below = {{(RHS_W-LHS_W){1'b0}}, lhs_reg} < rhs_full;

    always_comb begin
        priority if (overflow_reg) begin
            verdict_next = STAT_OVERFLOW;
        end else if (count_reg < min_intervals) begin
            verdict_next = STAT_TOO_FEW;
        end else if (sum_reg <= {{(SUM_W-CNT_W){1'b0}}, count_reg}) begin
            verdict_next = STAT_MEAN_SMALL;
        end else if (cv_below) begin
            verdict_next = STAT_REGULAR;
        end else begin
            verdict_next = STAT_IRREGULAR;
        end
    end

    // item capture and the arithmetic chain
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_item) begin
            iv_reg    <= interval_ms;
            iv_sq_reg <= interval_ms * interval_ms;
            last_reg  <= item_last;
        end
        if (dp_cmd.calc_product) begin
            s2_reg   <= sum_reg * sum_reg;
            lim2_reg <= max_cv_percent * max_cv_percent;
        end
        if (dp_cmd.calc_nq) begin
            nq_reg <= nq_full[S2_W-1:0];
        end
        if (dp_cmd.calc_diff) begin
            diff_reg <= (nq_reg > s2_reg) ? (nq_reg - s2_reg) : '0;
        end
        if (dp_cmd.calc_lhs) begin
            lhs_reg <= diff_reg * CV_SCALE_SQ;
        end
        if (dp_cmd.calc_rhs_lo) begin
            rhs_lo_reg <= s2_reg[SUM_W-1:0] * lim2_reg;
        end
        if (dp_cmd.calc_rhs_hi) begin
            rhs_hi_reg <= s2_reg[S2_W-1:SUM_W] * lim2_reg;
        end
        if (dp_cmd.calc_compare) begin
            verdict_reg <= verdict_next;
        end
        if (dp_cmd.load_result) begin
            m_status_reg <= verdict_reg;
        end
    end

    // set accumulators, cleared at reset and after every finished set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (dp_cmd.load_result) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sqsum_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (dp_cmd.accumulate) begin
            if (count_reg >= CNT_W'(MAX_INTERVALS)) begin
                // drop the interval, mark the set as too long
                overflow_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + {{(SUM_W-IV_W){1'b0}}, iv_reg};
                sqsum_reg <= sqsum_reg + {{(SQS_W-2*IV_W){1'b0}}, iv_sq_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dp_cmd.load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign dp_stat.item_last = last_reg;
    assign dp_stat.out_busy  = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-STAT_W-1){1'b0}}, m_status_reg,
                       (m_status_reg == STAT_REGULAR)};

endmodule

>>> sim/tb_beacon_interval_regularity_unit.sv
// Self-checking testbench for beacon_interval_regularity_unit: drives interval sets and
// register writes, predicts each set verdict and checks it against the result stream.
// Depends on bir_pkg and the unit's RTL.
module tb_beacon_interval_regularity_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bir_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int NUM_PHASES    = 7;

    typedef struct packed {
        logic    is_beacon;
        status_t status;
    } verdict_t;

    typedef enum int {SET_STEADY, SET_SCATTERED, SET_TINY, SET_NOISE} set_kind_t;

    // Tracks the accumulators and registers of the unit and queues set verdicts.
    class beacon_scoreboard;
        logic [CNT_W-1:0] min_cfg;
        logic [CV_W-1:0]  cv_cfg;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQS_W-1:0] sq_sum;
        bit               ovf;
        verdict_t         verdicts_due[$];
        int               errors;

        function new();
            min_cfg = MIN_INTERVALS_RST;
            cv_cfg  = MAX_CV_PERCENT_RST;
            errors  = 0;
            clear_set();
        endfunction

        function void clear_set();
            count  = '0;
            sum    = '0;
            sq_sum = '0;
            ovf    = 1'b0;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MIN_INTERVALS)
                min_cfg = data[CNT_W-1:0];
            else if (idx == REG_MAX_CV_PERCENT)
                cv_cfg = data[CV_W-1:0];
        endfunction

        function void note_interval(logic [IV_W-1:0] iv, logic last);
            verdict_t         v;
            logic [S2_W-1:0]  s2;
            logic [S2_W-1:0]  nq;
            logic [S2_W-1:0]  diff;
            logic [127:0]     lhs;
            logic [127:0]     rhs;
            logic [LIM2_W-1:0] lim2;
            if (int'(count) >= MAX_INTERVALS) begin
                ovf = 1'b1;
            end else begin
                count  = count + 1'b1;
                sum    = sum + SUM_W'(iv);
                sq_sum = sq_sum + SQS_W'(iv) * SQS_W'(iv);
            end
            if (!last)
                return;
            if (ovf) begin
                v.status = STAT_OVERFLOW;
            end else if (count < min_cfg) begin
                v.status = STAT_TOO_FEW;
            end else if (sum <= SUM_W'(count)) begin
                v.status = STAT_MEAN_SMALL;
            end else begin
                s2   = S2_W'(sum) * S2_W'(sum);
                nq   = S2_W'(count) * S2_W'(sq_sum);
                diff = (nq > s2) ? nq - s2 : '0;
                lim2 = LIM2_W'(cv_cfg) * LIM2_W'(cv_cfg);
                lhs  = 128'(diff) * 128'(CV_SCALE_SQ);
                rhs  = 128'(s2) * 128'(lim2);
                v.status = (lhs < rhs) ? STAT_REGULAR : STAT_IRREGULAR;
            end
            v.is_beacon = (v.status == STAT_REGULAR);
            verdicts_due.push_back(v);
            clear_set();
        endfunction

        function void check_verdict(logic [OUT_W-1:0] tdata);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                $error("unexpected result transaction: tdata=%0h", tdata);
                errors++;
                return;
            end
            v = verdicts_due.pop_front();
            if (tdata[0] !== v.is_beacon) begin
                $error("is_beacon: expected %0d, actual %0d", v.is_beacon, tdata[0]);
                errors++;
            end
            if (tdata[STAT_W:1] !== v.status) begin
                $error("status: expected %0d, actual %0d", v.status, tdata[STAT_W:1]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IV_W-1:0]       s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    beacon_scoreboard sb = new();
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int items_sent = 0;

    int phase_min[NUM_PHASES]    = '{8, 0, 1, 256, 3, 2, 511};
    int phase_cv[NUM_PHASES]     = '{30, 1000, 1, 50, 1023, 0, 700};
    int phase_items[NUM_PHASES]  = '{40, 40, 40, 20, 40, 40, 20};
    int phase_forced[NUM_PHASES] = '{0, 260, 0, 256, 0, 0, 0};

    beacon_interval_regularity_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_verdict(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    task automatic send_item(input logic [IV_W-1:0] iv, input logic last);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= iv;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_interval(iv, last);
        items_sent++;
    endtask

    task automatic send_set(input int len, input set_kind_t kind, input int jitter_pct);
        longint base;
        longint amp;
        longint v;
        case ($urandom_range(0, 3))
            0:       base = $urandom_range(2, 50);
            1, 2:    base = $urandom_range(50, 100000);
            default: base = $urandom_range(100000, 24'hFFFFFF);
        endcase
        amp = base * jitter_pct / 100;
        for (int i = 0; i < len; i++) begin
            case (kind)
                SET_STEADY:    v = base - amp + $urandom_range(0, 32'(2 * amp));
                SET_SCATTERED: v = $urandom_range(0, 32'(2 * base));
                SET_TINY:      v = $urandom_range(0, 3);
                default:       v = $urandom() & 24'hFFFFFF;
            endcase
            if (v > 24'hFFFFFF)
                v = 24'hFFFFFF;
            send_item(IV_W'(v), i == len - 1);
        end
    endtask

    // Hold the sender off until every verdict has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    initial begin
        int        start;
        int        len;
        set_kind_t kind;
        logic [CFG_DATA_W-1:0] junk;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 2) begin
                s_idle_pct = 12;
                m_idle_pct = 55;
            end else if (phase < 4) begin
                s_idle_pct = 55;
                m_idle_pct = 12;
            end else begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            if (phase == 0) begin
                // reset settings: steady, too few, mean of one, wildly irregular
                for (int i = 0; i < 8; i++)
                    send_item(IV_W'(1000), i == 7);
                send_item(24'hFFFFFF, 1'b1);
                for (int i = 0; i < 8; i++)
                    send_item(IV_W'(1), i == 7);
                for (int i = 0; i < 8; i++)
                    send_item((i % 2 == 0) ? 24'h000000 : 24'hFFFFFF, i == 7);
            end else begin
                wait_for_results();
                // a non-final interval may still be in flight
                repeat (SETTLE_CYCLES) @(posedge aclk);
                junk = (phase == 4) ? CFG_DATA_W'($urandom()) : '0;
                write_reg(REG_MIN_INTERVALS,
                          {junk[CFG_DATA_W-1:CNT_W], CNT_W'(phase_min[phase])});
                write_reg(REG_MAX_CV_PERCENT,
                          {junk[CFG_DATA_W-1:CV_W], CV_W'(phase_cv[phase])});
                if (phase == 4)
                    write_reg(REG_MAX_CV_PERCENT + CFG_IDX_W'(1 + $urandom_range(0, 200)),
                              CFG_DATA_W'($urandom()));
                cfg_valid <= 1'b0;
                @(posedge aclk);
            end
            if (phase_forced[phase] != 0) begin
                send_set(phase_forced[phase], SET_STEADY, 0);
                wait_for_results();
            end
            start = items_sent;
            while (items_sent - start < phase_items[phase]) begin
                case ($urandom_range(0, 9))
                    0, 1:    kind = SET_NOISE;
                    2:       kind = SET_TINY;
                    3, 4:    kind = SET_SCATTERED;
                    default: kind = SET_STEADY;
                endcase
                if (kind == SET_NOISE || $urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 40);
                else
                    len = int'(sb.min_cfg) + int'($urandom_range(0, 6)) - 3;
                if (len < 1)
                    len = 1;
                send_set(len, kind, $urandom_range(0, 60));
                if ($urandom_range(0, 19) == 0)
                    wait_for_results();
            end
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("beacon_interval_regularity_unit: match");
        else
            $display("beacon_interval_regularity_unit: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("beacon_interval_regularity_unit: mismatch");
        $finish;
    end

endmodule
